/* rtl/text_console_writer_unit_defines.svh */
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define TCW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define TCW_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCW_ASSERT_IMP(name, ante, cons)
`define TCW_ASSERT_NXT(name, ante, cons)
`endif

`endif

/* rtl/tcw_pkg.sv */
// Shared constants and controller/datapath interface types of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [7:0] CHAR_PRINT_HI = 8'd127;
    localparam logic [7:0] RESET_ATTR    = 8'd7;

    localparam int         APB_ADDR_W     = 2;
    localparam logic [1:0] ADDR_FILL_ATTR = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sweep_reset;
        logic put_char;
        logic line_break;
        logic sweep_row;
        logic capture;
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_print;
        logic is_break;
        logic wraps;
        logic sweep_last_cell;
        logic sweep_last_col;
    } tcw_status_t;

endpackage

`default_nettype wire

/* rtl/text_console_writer_unit.sv */
// Top level of the text console writer: ROWS x COLUMNS text screen with cursor and scroll.
// A put or read request passes the decode and finish states before its result strobe;
// a put that scrolls also passes the scroll state between them to clear the new bottom row in the screen RAMs.
// A new request is accepted only once the previous one is finished (single RAM port).
// Reset: the screen RAMs are swept to spaces with attribute 7, one cell per cycle,
// after reset; busy stays high meanwhile. Results cannot stall.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Request channel: accepted when start is high and busy is low.
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           command,
    input  wire logic [7:0]                     char_code,
    input  wire logic [10:0]                    cell_index,

    // Result channel: valid for exactly one cycle while done is high.
    output logic                                done,
    output logic      [7:0]                     cell_char,
    output logic      [7:0]                     cell_attr,
    output logic      [10:0]                    cursor_cell,
    output logic                                scrolled,

    // Configuration port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    // The screen lives in two RAMs, characters and attributes, addressed
    // physically. A rotating row offset in the datapath maps logical cells to
    // physical ones, so a scroll only moves the offset by one row and clears
    // that one row rather than copying the whole screen.

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;
    logic [7:0]           fill_attr;

    // The configuration block holds the attribute used for rows cleared on scroll.
    tcw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fill_attr (fill_attr)
    );

    // The controller sequences the reset sweep, each request and the row clear.
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath keeps the cursor, the row offset, the RAMs and the result registers.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .fill_attr   (fill_attr),
        .command     (command),
        .char_code   (char_code),
        .cell_index  (cell_index),
        .done        (done),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .cursor_cell (cursor_cell),
        .scrolled    (scrolled)
    );

endmodule

`default_nettype wire

/* rtl/tcw_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/tcw_cfg.sv */
// APB-style configuration register block holding the fill attribute.
`default_nettype none

module tcw_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output logic      [7:0]                      fill_attr
);

    logic [7:0] fill_attr_reg;
    logic [7:0] fill_attr_next;

    always_comb
    begin
        fill_attr_next = fill_attr_reg;
        if (psel && penable && pwrite && (paddr == tcw_pkg::ADDR_FILL_ATTR))
        begin
            fill_attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_attr_reg <= tcw_pkg::RESET_ATTR;
        end
        else
        begin
            fill_attr_reg <= fill_attr_next;
        end
    end

    assign prdata    = (paddr == tcw_pkg::ADDR_FILL_ATTR) ? {24'd0, fill_attr_reg} : 32'd0;
    assign pready    = 1'b1;
    assign fill_attr = fill_attr_reg;

endmodule

`default_nettype wire

/* rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_reset = 1'b1;
                if (status.sweep_last_cell)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // A read only needs the RAM address presented this cycle.
                state_next = S_FINISH;
                if (status.is_print)
                begin
                    cmd.put_char = 1'b1;
                    if (status.wraps)
                    begin
                        state_next = S_SCROLL;
                    end
                end
                else if (status.is_break)
                begin
                    cmd.line_break = 1'b1;
                    if (status.wraps)
                    begin
                        state_next = S_SCROLL;
                    end
                end
            end
            S_SCROLL:
            begin
                cmd.sweep_row = 1'b1;
                if (status.sweep_last_col)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.capture = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `TCW_ASSERT_NXT(a_start_decodes, (state_reg == S_IDLE) && start, state_reg == S_DECODE)
    `TCW_ASSERT_NXT(a_finish_returns_idle, state_reg == S_FINISH, state_reg == S_IDLE)

endmodule

`default_nettype wire

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: cursor, row ring offset, screen RAMs, result registers.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcw_pkg::tcw_cmd_t    cmd,
    output tcw_pkg::tcw_status_t      status,
    input  wire logic [7:0]           fill_attr,
    input  wire logic                 command,
    input  wire logic [7:0]           char_code,
    input  wire logic [10:0]          cell_index,
    output logic                      done,
    output logic      [7:0]           cell_char,
    output logic      [7:0]           cell_attr,
    output logic      [10:0]          cursor_cell,
    output logic                      scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM       = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_SWEEP   = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STEP     = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);
    localparam logic [10:0]   BOTTOM_OUT   = 11'(CELLS - COLUMNS);

    // Latched request.
    logic          command_reg;
    logic [7:0]    code_reg;
    logic [10:0]   index_reg;

    // Control state.
    logic [AW-1:0] cursor_reg,     cursor_next;
    logic [CW-1:0] col_reg,        col_next;
    logic [AW-1:0] top_reg,        top_next;
    logic [AW-1:0] clear_base_reg, clear_base_next;
    logic [AW-1:0] sweep_reg,      sweep_next;
    logic          scrolled_reg,   scrolled_next;
    logic          done_reg,       done_next;

    // Result registers.
    logic [7:0]    cell_char_reg;
    logic [7:0]    cell_attr_reg;
    logic [10:0]   cursor_cell_reg;
    logic          scrolled_out_reg;

    logic [31:0]   op_wide;
    logic [31:0]   sum_wide;
    logic [31:0]   phys_wide;
    logic [31:0]   cursor_wide;
    logic [31:0]   break_wide;
    logic [AW-1:0] phys_addr;
    logic          in_range;
    logic          is_print;
    logic          is_break;
    logic          wraps;

    logic          ram_we_char;
    logic          ram_we_attr;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata_char;
    logic [7:0]    ram_wdata_attr;
    logic [7:0]    rd_char;
    logic [7:0]    rd_attr;

    // Logical cell to physical RAM address through the rotating row offset.
    always_comb
    begin
        op_wide   = command_reg ? 32'(index_reg) : 32'(cursor_reg);
        sum_wide  = op_wide + 32'(top_reg);
        phys_wide = (sum_wide >= 32'(CELLS)) ? (sum_wide - 32'(CELLS)) : sum_wide;
        phys_addr = phys_wide[AW-1:0];
    end

    assign in_range    = (32'(index_reg) < 32'(CELLS));
    assign is_print    = !command_reg && (code_reg >= tcw_pkg::CHAR_PRINT_LO)
                         && (code_reg <= tcw_pkg::CHAR_PRINT_HI);
    assign is_break    = !command_reg && ((code_reg == tcw_pkg::CHAR_LF)
                         || (code_reg == tcw_pkg::CHAR_CR));
    assign wraps       = is_print ? (cursor_reg == LAST_CELL) : (cursor_reg >= BOTTOM);
    assign cursor_wide = 32'(cursor_reg);
    assign break_wide  = cursor_wide + 32'(COLUMNS) - 32'(col_reg);

    always_comb
    begin
        status                 = '0;
        status.is_print        = is_print;
        status.is_break        = is_break;
        status.wraps           = wraps;
        status.sweep_last_cell = (sweep_reg == LAST_CELL);
        status.sweep_last_col  = (sweep_reg == LAST_SWEEP);
    end

    always_comb
    begin
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        top_next        = top_reg;
        clear_base_next = clear_base_reg;
        sweep_next      = sweep_reg;
        scrolled_next   = scrolled_reg;
        done_next       = cmd.capture;

        if (cmd.load)
        begin
            scrolled_next = 1'b0;
        end

        if (cmd.sweep_reset)
        begin
            sweep_next = status.sweep_last_cell ? '0 : (sweep_reg + 1'b1);
        end
        else if (cmd.sweep_row)
        begin
            sweep_next = status.sweep_last_col ? '0 : (sweep_reg + 1'b1);
        end

        if (cmd.put_char || cmd.line_break)
        begin
            if (wraps)
            begin
                // The old top row becomes the new, blank bottom row.
                top_next        = (top_reg == BOTTOM) ? '0 : (top_reg + ROW_STEP);
                clear_base_next = top_reg;
                cursor_next     = BOTTOM;
                col_next        = '0;
                scrolled_next   = 1'b1;
                sweep_next      = '0;
            end
            else if (cmd.put_char)
            begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == COL_LAST) ? '0 : (col_reg + 1'b1);
            end
            else
            begin
                cursor_next = break_wide[AW-1:0];
                col_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            col_reg        <= '0;
            top_reg        <= '0;
            clear_base_reg <= '0;
            sweep_reg      <= '0;
            scrolled_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            top_reg        <= top_next;
            clear_base_reg <= clear_base_next;
            sweep_reg      <= sweep_next;
            scrolled_reg   <= scrolled_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= command;
            code_reg    <= char_code;
            index_reg   <= cell_index;
        end
        if (cmd.capture)
        begin
            cell_char_reg    <= (command_reg && in_range) ? rd_char : 8'd0;
            cell_attr_reg    <= (command_reg && in_range) ? rd_attr : 8'd0;
            cursor_cell_reg  <= cursor_wide[10:0];
            scrolled_out_reg <= scrolled_reg;
        end
    end

    // RAM port steering.
    assign ram_we_char    = cmd.sweep_reset || cmd.sweep_row || cmd.put_char;
    assign ram_we_attr    = cmd.sweep_reset || cmd.sweep_row;
    assign ram_wdata_char = cmd.put_char ? code_reg : tcw_pkg::CHAR_SPACE;
    assign ram_wdata_attr = cmd.sweep_reset ? tcw_pkg::RESET_ATTR : fill_attr;

    always_comb
    begin
        priority if (cmd.sweep_reset)
        begin
            ram_addr = sweep_reg;
        end
        else if (cmd.sweep_row)
        begin
            ram_addr = clear_base_reg + sweep_reg;
        end
        else
        begin
            ram_addr = phys_addr;
        end
    end

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we_char),
        .addr  (ram_addr),
        .wdata (ram_wdata_char),
        .rdata (rd_char)
    );

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (ram_we_attr),
        .addr  (ram_addr),
        .wdata (ram_wdata_attr),
        .rdata (rd_attr)
    );

    assign done        = done_reg;
    assign cell_char   = cell_char_reg;
    assign cell_attr   = cell_attr_reg;
    assign cursor_cell = cursor_cell_reg;
    assign scrolled    = scrolled_out_reg;

    `TCW_ASSERT_IMP(a_cursor_in_screen, 1'b1, 32'(cursor_reg) < 32'(CELLS))
    `TCW_ASSERT_IMP(a_scroll_lands_bottom, done_reg && scrolled_out_reg, cursor_cell_reg == BOTTOM_OUT)

endmodule

`default_nettype wire
